// ===== rtl/window_trimmed_local_variance_assert.svh =====
// Assertion macros for the trimmed local variance block.
`ifndef WINDOW_TRIMMED_LOCAL_VARIANCE_ASSERT_SVH
`define WINDOW_TRIMMED_LOCAL_VARIANCE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WTLV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define WTLV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/wtlv_pkg.sv =====
// Shared types and constants of the trimmed local variance block.
package wtlv_pkg;

  localparam int DEF_WIN_ROWS    = 3;
  localparam int DEF_WIN_COLS    = 3;
  localparam int DEF_MAX_WIDTH   = 2048;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int MAX_HEIGHT      = 4096;

  localparam int CFG_W_BITS = 12;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_F_BITS = 9;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int PIX_W      = 25;
  localparam int VAR_W      = 40;

  localparam logic [CFG_W_BITS-1:0] RST_WIDTH  = 12'd2048;
  localparam logic [CFG_H_BITS-1:0] RST_HEIGHT = 13'd4096;
  localparam logic [CFG_F_BITS-1:0] FRAC_ONE   = 9'd256;
  localparam logic [VAR_W-1:0]      VAR_MAX    = 40'hFF_FFFF_FFFF;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KEEP_FRAC    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_KSEL,
    ST_SUM,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_FIN
  } wtlv_state_e;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shf;
  } cell_ctl_t;

endpackage

// ===== rtl/wtlv_cell.sv =====
// One cell of the sorting chain: holds one sample, kept in descending order.
module wtlv_cell import wtlv_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cell_ctl_t                     ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] new_i,
  input  logic                          prev_ge_i,
  input  logic                          prev_ok_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_val_i,
  input  logic                          next_ok_i,
  input  logic signed [SAMPLE_BITS-1:0] next_val_i,
  output logic                          ok_o,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic                          ge_o
);

  logic                          ok_q, ok_d;
  logic signed [SAMPLE_BITS-1:0] val_q, val_d;

  assign ge_o  = ok_q && (val_q >= new_i);
  assign ok_o  = ok_q;
  assign val_o = val_q;

  // On insert a cell keeps its value if it is not smaller than the new one,
  // takes the new value if its upper neighbor keeps, and otherwise takes the
  // neighbor's value as everything below the insertion point moves down.
  always_comb begin
    ok_d  = ok_q;
    val_d = val_q;
    if (ctl_i.clr) begin
      ok_d = 1'b0;
    end else if (ctl_i.shf) begin
      ok_d  = next_ok_i;
      val_d = next_val_i;
    end else if (ctl_i.ins && !ge_o) begin
      if (prev_ge_i) begin
        ok_d  = 1'b1;
        val_d = new_i;
      end else begin
        ok_d  = prev_ok_i;
        val_d = prev_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/wtlv_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wtlv_div import wtlv_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dvd_i,
  input  logic [DW-1:0] dvs_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc_q;
  logic [DW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   rem_sh;
  logic          qbit;

  assign rem_sh = {rem_q, acc_q[NW-1]};
  assign qbit   = rem_sh >= {1'b0, dvs_i};
  assign done_o = done_q;
  assign quo_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dvd_i;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[NW-2:0], qbit};
      rem_q <= qbit ? DW'(rem_sh - {1'b0, dvs_i}) : rem_sh[DW-1:0];
    end
  end

endmodule

// ===== rtl/window_trimmed_local_variance.sv =====
// Top level of the trimmed local variance block.
// Pixels enter in raster order and each is written to a ring store holding the
// last WIN_ROWS lines; results leave in raster order, lagging the input by
// (WIN_ROWS/2)*width + WIN_COLS/2 items, and flush items drain that lag. An item
// that causes no result does not stall the input; one that causes a result
// stalls it until the result is loaded into the output register: the window is
// read one entry per cycle from the line store into a chain of sorting cells,
// the kept values are shifted out and accumulated one per cycle, and the
// bit-serial divider, whose quotient is 48 bits wide at the default sizes,
// dominates. When fewer than two neighbors are kept, or the anchor is not valid,
// the sums and the divider are skipped. After a configuration write the input
// stalls in the following cycle. The line store has no clearing pass; only
// pixels of the current image are ever read from it.
module window_trimmed_local_variance import wtlv_pkg::*; #(
  parameter int WIN_ROWS    = DEF_WIN_ROWS,
  parameter int WIN_COLS    = DEF_WIN_COLS,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          sample_ok_i,
  input  logic                          anchor_ok_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VAR_W-1:0]              variance_q8_o,
  output logic                          variance_ok_o,
  output logic                          image_done_o
);

`include "window_trimmed_local_variance_assert.svh"

  localparam int LEG_R = WIN_ROWS / 2;
  localparam int LEG_C = WIN_COLS / 2;
  localparam int N     = WIN_ROWS * WIN_COLS;
  localparam int RING  = WIN_ROWS * MAX_WIDTH + WIN_COLS;
  localparam int AW    = $clog2(RING);
  localparam int KW    = $clog2(N + 1);
  localparam int SW    = SAMPLE_BITS + KW + 1;
  localparam int S2W   = 2 * SAMPLE_BITS + KW;
  localparam int NUMW  = KW + S2W;
  localparam int QW    = NUMW + 8;
  localparam int QX    = (QW > VAR_W + 1) ? QW : VAR_W + 1;
  localparam int DENW  = 2 * KW;
  localparam int MW    = SAMPLE_BITS + 2;
  localparam int RIW   = $clog2(WIN_ROWS + 1);
  localparam int CIW   = $clog2(WIN_COLS + 1);
  localparam int NFW   = KW + CFG_F_BITS;

  // Configuration
  logic [CFG_W_BITS-1:0] cfg_w_q;
  logic [CFG_H_BITS-1:0] cfg_h_q;
  logic [CFG_F_BITS-1:0] cfg_f_q;
  logic                  cfg_wr, cfg_hit, cfg_busy_q;
  logic [CFG_W_BITS-1:0] weff;
  logic [CFG_H_BITS-1:0] heff;
  logic [PIX_W-1:0]      total_q, lag_q;
  logic [AW-1:0]         lag_a_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // Only a write to an existing register abandons the image in progress.
  assign cfg_hit = cfg_wr &&
                   (paddr[3:2] inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_KEEP_FRAC});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= RST_WIDTH;
      cfg_h_q    <= RST_HEIGHT;
      cfg_f_q    <= FRAC_ONE;
      cfg_busy_q <= 1'b0;
    end else begin
      cfg_busy_q <= cfg_wr;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_IMAGE_WIDTH:  cfg_w_q <= pwdata[CFG_W_BITS-1:0];
          REG_IMAGE_HEIGHT: cfg_h_q <= pwdata[CFG_H_BITS-1:0];
          REG_KEEP_FRAC: begin
            cfg_f_q <= (pwdata[CFG_F_BITS-1:0] > FRAC_ONE) ? FRAC_ONE
                                                           : pwdata[CFG_F_BITS-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(cfg_w_q);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(cfg_h_q);
      REG_KEEP_FRAC:    prdata = PDATA_W'(cfg_f_q);
      default:          prdata = '0;
    endcase
  end

  assign weff = (cfg_w_q == '0) ? CFG_W_BITS'(1) :
                (32'(cfg_w_q) > 32'(MAX_WIDTH)) ? CFG_W_BITS'(MAX_WIDTH) : cfg_w_q;
  assign heff = (cfg_h_q == '0) ? CFG_H_BITS'(1) :
                (32'(cfg_h_q) > 32'(MAX_HEIGHT)) ? CFG_H_BITS'(MAX_HEIGHT) : cfg_h_q;

  always_ff @(posedge clk_i) begin
    total_q <= PIX_W'(weff) * PIX_W'(heff);
    lag_q   <= PIX_W'(LEG_R) * PIX_W'(weff) + PIX_W'(LEG_C);
    lag_a_q <= AW'(LEG_R * 1) * AW'(weff) + AW'(LEG_C);
  end

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= (AW+1)'(RING)) t = t - (AW+1)'(RING);
    return t[AW-1:0];
  endfunction

  // Handshake and stream counters
  wtlv_state_e state_q, state_d;
  logic        in_acc, is_pix, complete, emit, last_pix;
  logic [PIX_W-1:0] pin_q, pin_n, q_q;
  logic [CFG_H_BITS-1:0] orow_q;
  logic [CFG_W_BITS-1:0] ocol_q;
  logic [AW-1:0] wa_q, oa_q;

  assign in_stall_o = (state_q != ST_IDLE) || cfg_busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_pix     = !func_i && (pin_q < total_q);
  assign pin_n      = pin_q + PIX_W'(is_pix);
  assign complete   = pin_n >= total_q;
  assign emit       = (q_q < total_q) && (complete || (is_pix && (pin_n > q_q + lag_q)));
  assign last_pix   = q_q == total_q - PIX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q  <= '0;
      q_q    <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      wa_q   <= '0;
      oa_q   <= '0;
    end else if (cfg_hit || (in_acc && emit && last_pix)) begin
      pin_q  <= '0;
      q_q    <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      wa_q   <= '0;
      oa_q   <= '0;
    end else if (in_acc) begin
      pin_q <= pin_n;
      if (is_pix) begin
        wa_q <= ring_add(wa_q, AW'(1));
      end
      if (emit) begin
        q_q  <= q_q + PIX_W'(1);
        oa_q <= ring_add(oa_q, AW'(1));
        if (ocol_q == weff - CFG_W_BITS'(1)) begin
          ocol_q <= '0;
          orow_q <= orow_q + CFG_H_BITS'(1);
        end else begin
          ocol_q <= ocol_q + CFG_W_BITS'(1);
        end
      end
    end
  end

  // Line store
  logic [MW-1:0] mem [RING];
  logic [MW-1:0] rdata_q;
  logic [AW-1:0] ga_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && is_pix) begin
      mem[wa_q] <= {anchor_ok_i, sample_ok_i, sample_i};
    end
    rdata_q <= mem[ga_q];
  end

  // Window gather
  logic [CFG_W_BITS-1:0]  cen_col_q;
  logic                   cen_last_q;
  logic signed [CFG_H_BITS:0] grow_q;
  logic signed [CFG_W_BITS:0] gcol_q;
  logic [AW-1:0]          grs_q, grs_n;
  logic [RIW-1:0]         gi_q;
  logic [CIW-1:0]         gj_q;
  logic                   gdone_q, rdv_q, rdcen_q, inb;
  logic                   anchor_q;
  logic [KW-1:0]          n_q;
  logic [AW-1:0]          ga_start;

  assign inb = (grow_q >= 0) && (grow_q < $signed({1'b0, heff})) &&
               (gcol_q >= 0) && (gcol_q < $signed({1'b0, weff}));
  assign grs_n    = ring_add(grs_q, AW'(weff));
  assign ga_start = (oa_q >= lag_a_q) ? oa_q - lag_a_q : AW'(oa_q + AW'(RING) - lag_a_q);

  // Sorting chain
  cell_ctl_t ctl;
  logic                          chain_ok  [N];
  logic signed [SAMPLE_BITS-1:0] chain_val [N];
  logic                          chain_ge  [N];
  logic signed [SAMPLE_BITS-1:0] new_val;

  assign new_val = rdata_q[SAMPLE_BITS-1:0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                          p_ge, p_ok, n_ok;
    logic signed [SAMPLE_BITS-1:0] p_val, n_val;
    if (i == 0) begin : g_first
      assign p_ge  = 1'b1;
      assign p_ok  = 1'b0;
      assign p_val = '0;
    end else begin : g_mid
      assign p_ge  = chain_ge[i-1];
      assign p_ok  = chain_ok[i-1];
      assign p_val = chain_val[i-1];
    end
    if (i == N - 1) begin : g_last
      assign n_ok  = 1'b0;
      assign n_val = '0;
    end else begin : g_body
      assign n_ok  = chain_ok[i+1];
      assign n_val = chain_val[i+1];
    end
    wtlv_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .new_i      (new_val),
      .prev_ge_i  (p_ge),
      .prev_ok_i  (p_ok),
      .prev_val_i (p_val),
      .next_ok_i  (n_ok),
      .next_val_i (n_val),
      .ok_o       (chain_ok[i]),
      .val_o      (chain_val[i]),
      .ge_o       (chain_ge[i])
    );
  end

  // Trim, sums and divide
  logic [NFW-1:0]        nf;
  logic [KW-1:0]         k_sel, k_q, cnt_q;
  logic signed [SW-1:0]  s_q;
  logic [S2W-1:0]        s2_q;
  logic signed [2*SAMPLE_BITS-1:0] sq0;
  logic signed [2*SW-1:0] ssq;
  logic [NUMW-1:0]       p1_q, p2_q;
  logic [DENW-1:0]       den_q;
  logic                  div_start, div_done;
  logic [QX-1:0]         div_quo;
  logic [VAR_W-1:0]      res_var_q;
  logic                  res_ok_q;
  logic                  out_load;

  assign nf    = anchor_q ? NFW'(n_q) * NFW'(cfg_f_q) : '0;
  assign k_sel = (cfg_f_q >= FRAC_ONE) ? n_q : KW'(nf >> 8);
  assign sq0   = chain_val[0] * chain_val[0];
  assign ssq   = s_q * s_q;

  wtlv_div #(.NW(QX), .DW(DENW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (QX'({p1_q - p2_q, 8'b0})),
    .dvs_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    ctl       = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && emit) state_d = ST_GATHER;
      end
      ST_GATHER: begin
        ctl.ins = rdv_q && rdata_q[SAMPLE_BITS];
        if (gdone_q) state_d = ST_KSEL;
      end
      ST_KSEL: begin
        if (nf < NFW'(256) || k_sel < KW'(2)) state_d = ST_FIN;
        else state_d = ST_SUM;
      end
      ST_SUM: begin
        ctl.shf = 1'b1;
        if (cnt_q == KW'(1)) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_DIVS;
      ST_DIVS: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          ctl.clr  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gdone_q <= 1'b0;
      rdv_q   <= 1'b0;
      rdcen_q <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      rdv_q   <= (state_q == ST_GATHER) && !gdone_q && inb;
      rdcen_q <= (state_q == ST_GATHER) && !gdone_q &&
                 (gi_q == RIW'(LEG_R)) && (gj_q == CIW'(LEG_C));
      if (state_q == ST_IDLE) begin
        gdone_q <= 1'b0;
        n_q     <= '0;
      end else if (state_q == ST_GATHER) begin
        if (gi_q == RIW'(WIN_ROWS - 1) && gj_q == CIW'(WIN_COLS - 1)) gdone_q <= 1'b1;
        if (ctl.ins) n_q <= n_q + KW'(1);
      end
    end
  end

  // Gather address walk and arithmetic datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      cen_col_q  <= ocol_q;
      cen_last_q <= last_pix;
      grow_q     <= $signed({1'b0, orow_q}) - (CFG_H_BITS+1)'(LEG_R);
      gcol_q     <= $signed({1'b0, ocol_q}) - (CFG_W_BITS+1)'(LEG_C);
      ga_q       <= ga_start;
      grs_q      <= ga_start;
      gi_q       <= '0;
      gj_q       <= '0;
    end else if (state_q == ST_GATHER && !gdone_q) begin
      if (gj_q == CIW'(WIN_COLS - 1)) begin
        gj_q   <= '0;
        gi_q   <= gi_q + RIW'(1);
        grow_q <= grow_q + (CFG_H_BITS+1)'(1);
        gcol_q <= $signed({1'b0, cen_col_q}) - (CFG_W_BITS+1)'(LEG_C);
        grs_q  <= grs_n;
        ga_q   <= grs_n;
      end else begin
        gj_q   <= gj_q + CIW'(1);
        gcol_q <= gcol_q + (CFG_W_BITS+1)'(1);
        ga_q   <= ring_add(ga_q, AW'(1));
      end
    end
    if (state_q == ST_GATHER && rdcen_q) anchor_q <= rdata_q[SAMPLE_BITS+1];
    if (state_q == ST_KSEL) begin
      k_q       <= k_sel;
      cnt_q     <= k_sel;
      s_q       <= '0;
      s2_q      <= '0;
      res_var_q <= '0;
      res_ok_q  <= nf >= NFW'(256);
    end
    if (state_q == ST_SUM) begin
      cnt_q <= cnt_q - KW'(1);
      s_q   <= s_q + SW'(chain_val[0]);
      s2_q  <= s2_q + S2W'($unsigned(sq0));
    end
    if (state_q == ST_MUL) begin
      // The pairwise squared differences sum to k*sum(x^2) - (sum x)^2.
      p1_q  <= NUMW'(k_q) * NUMW'(s2_q);
      p2_q  <= NUMW'($unsigned(ssq));
      den_q <= DENW'(k_q) * DENW'(k_q - KW'(1));
    end
    if (state_q == ST_DIVW && div_done) begin
      res_var_q <= (div_quo > QX'(VAR_MAX)) ? VAR_MAX : div_quo[VAR_W-1:0];
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      variance_q8_o <= res_ok_q ? res_var_q : '0;
      variance_ok_o <= res_ok_q;
      image_done_o  <= cen_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `WTLV_ASSERT_IMP(a_load_free, out_load && out_valid_q, !out_stall_i)
  `WTLV_ASSERT_IMP(a_n_bound, state_q != ST_IDLE, n_q <= KW'(N))
  `WTLV_ASSERT_NEXT(a_emit_gathers, in_acc && emit, state_q == ST_GATHER)
  `WTLV_ASSERT_IMP(a_out_behind_in, state_q == ST_IDLE, q_q <= pin_q)

endmodule
